// ===== rtl/rat_pkg.sv =====
`default_nettype none

package rat_pkg;

    // Width of the timestamp, the period entries, the numerator and the quotient
    localparam int unsigned DATA_W = 32;

    // Microseconds in one minute
    localparam longint unsigned MICROS_PER_MINUTE = 64'd60000000;

    // Restoring divide: one quotient bit per step
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Request kinds carried on the input tuser bit
    localparam logic REQ_MARK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic mark_wr;     // store a period, advance the slot
        logic read_start;  // capture the fresh flag, clear the walk
        logic walk;        // read one ring entry, advance the walk address
        logic div_load;    // seed the divider
        logic div_step;    // one restoring divide step
        logic out_load;    // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk_last;   // walk address sits on the last ring entry
        logic sum_zero;    // accumulated period sum is zero
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/rat_dp.sv =====
`default_nettype none

module rat_dp #(
    parameter int unsigned RING_LEN = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire rat_pkg::t_cmd             i_cmd,
    input  wire [rat_pkg::DATA_W-1:0]      i_stamp,
    output rat_pkg::t_sts                  o_sts,
    output logic [rat_pkg::DATA_W-1:0]     o_rpm,
    output logic                           o_fresh,
    output logic                           o_zero
);

    localparam int unsigned IDX_W = $clog2(RING_LEN);
    localparam int unsigned SUM_W = rat_pkg::DATA_W + IDX_W;
    localparam int unsigned DW    = rat_pkg::DATA_W;
    localparam logic [63:0] NUM64 = rat_pkg::MICROS_PER_MINUTE * 64'(RING_LEN - 1);
    localparam logic [DW-1:0] NUMER = NUM64[DW-1:0];

    // Period ring
    logic [DW-1:0]       mem [RING_LEN];
    logic [RING_LEN-1:0] r_valid;
    logic [IDX_W-1:0]    r_slot;
    logic [DW-1:0]       r_prev;
    logic                r_mark_seen;

    // Sum walk
    logic [IDX_W-1:0]    r_addr;
    logic [IDX_W-1:0]    r_pend_idx;
    logic                r_pend;
    logic [DW-1:0]       r_rd_data;
    logic                r_rd_vld;
    logic [SUM_W-1:0]    r_acc;
    logic                r_fresh;

    // Divider
    logic [SUM_W-1:0]    r_rem;
    logic [DW-1:0]       r_quo;
    logic [SUM_W:0]      shifted;
    logic                ge;

    // Result
    logic [DW-1:0]       r_rpm;
    logic                r_fresh_out;
    logic                r_zero_out;

    logic [DW-1:0]       period;
    logic                last_slot;

    assign period    = i_stamp - r_prev;
    assign last_slot = (r_slot == IDX_W'(RING_LEN - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_wr) begin
            mem[r_slot] <= period;
        end
        if (i_cmd.walk) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_slot      <= '0;
            r_prev      <= '0;
            r_mark_seen <= 1'b0;
            r_pend      <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (i_cmd.mark_wr) begin
                r_valid[r_slot] <= 1'b1;
                r_slot          <= last_slot ? '0 : r_slot + 1'b1;
                r_prev          <= i_stamp;
                r_mark_seen     <= 1'b1;
            end
            if (i_cmd.read_start) begin
                r_mark_seen <= 1'b0;
                r_addr      <= '0;
            end else if (i_cmd.walk) begin
                r_addr <= r_addr + 1'b1;
            end
            r_pend <= i_cmd.walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_start) begin
            r_fresh <= r_mark_seen;
        end
        if (i_cmd.walk) begin
            r_pend_idx <= r_addr;
            r_rd_vld   <= r_valid[r_addr];
        end
        // Skip the entry at the write slot and entries never written
        if (i_cmd.read_start) begin
            r_acc <= '0;
        end else if (r_pend && r_rd_vld && (r_pend_idx != r_slot)) begin
            r_acc <= r_acc + SUM_W'(r_rd_data);
        end
    end

    assign shifted = {r_rem, r_quo[DW-1]};
    assign ge      = (shifted >= {1'b0, r_acc});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= NUMER;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? SUM_W'(shifted - {1'b0, r_acc}) : shifted[SUM_W-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_rpm       <= (r_acc == '0) ? '1 : r_quo;
            r_zero_out  <= (r_acc == '0);
            r_fresh_out <= r_fresh;
        end
    end

    assign o_sts.walk_last = (r_addr == IDX_W'(RING_LEN - 1));
    assign o_sts.sum_zero  = (r_acc == '0);
    assign o_rpm           = r_rpm;
    assign o_fresh         = r_fresh_out;
    assign o_zero          = r_zero_out;

endmodule

`default_nettype wire

// ===== rtl/rat_ctrl.sv =====
`default_nettype none

module rat_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    input  wire                 i_req_type,
    input  wire                 i_out_ready,
    input  wire rat_pkg::t_sts  i_sts,
    output logic                o_req_ready,
    output logic                o_out_valid,
    output rat_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_LOAD,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic [rat_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                            r_out_valid;
    logic                            accept;
    logic                            out_free;

    assign accept   = (r_state == S_IDLE) && i_req_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.mark_wr    = accept && (i_req_type == rat_pkg::REQ_MARK);
        o_cmd.read_start = accept && (i_req_type == rat_pkg::REQ_READ);
        o_cmd.walk       = (r_state == S_WALK);
        o_cmd.div_load   = (r_state == S_LOAD);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.out_load   = (r_state == S_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.read_start) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_sts.walk_last) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    // Zero sum saturates: skip the divide
                    r_state <= i_sts.sum_zero ? S_FINISH : S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == rat_pkg::DIV_CNT_W'(rat_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/rolling_average_tachometer.sv =====
`default_nettype none

// Channel   Dir  tdata                      tuser
// s_axis    in   [31:0] timestamp_us        [0] req_type (0 mark, 1 read)
// m_axis    out  [31:0] speed_rpm           [0] fresh, [1] zero_sum
//
// A mark request produces no response.
// A read request walks the period ring memory (one entry per cycle through
// its single read port), then runs a 32-step restoring divide; a zero sum
// skips the divide.
// Reset clears the ring through per-entry valid bits; no clearing pass.
// The response register lets a new request in while the last response waits;
// a finished read holds in place until that register is free.

module rolling_average_tachometer #(
    parameter int unsigned RING_LEN = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] timestamp_us
    input  wire  [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] speed_rpm
    output logic [1:0]  m_axis_tuser    // [0] fresh, [1] zero_sum
);

    rat_pkg::t_cmd cmd;
    rat_pkg::t_sts sts;
    logic          fresh;
    logic          zero;

    // Sequence the request: mark write, sum walk, divide, response
    rat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser[0]),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_req_ready (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Hold the ring, the running sum, the divider and the response register
    rat_dp #(
        .RING_LEN (RING_LEN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_stamp (s_axis_tdata),
        .o_sts   (sts),
        .o_rpm   (m_axis_tdata),
        .o_fresh (fresh),
        .o_zero  (zero)
    );

    assign m_axis_tuser = {zero, fresh};

endmodule

`default_nettype wire

// ===== sim/rolling_average_tachometer_tb.sv =====
`default_nettype none

module rolling_average_tachometer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING_LEN    = 8;
    localparam int unsigned RANDOM_REQS = 1430;
    // Tail wait after the drain, longer than one read takes
    localparam int unsigned TAIL_CYCLES = RING_LEN + 60;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RX_HOLD     = 400;
    localparam int unsigned MAX_REPORTS = 10;

    // One speed response as the block returns it
    typedef struct packed {
        logic [31:0] speed_rpm;
        logic        fresh;
        logic        zero_sum;
    } t_rpm_reading;

    // Directed stimulus row; typed rows carry their response written out by hand
    typedef struct packed {
        logic         kind;
        logic [31:0]  stamp;
        logic         typed;
        t_rpm_reading reading;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] timestamp_us
    logic [0:0]  s_axis_tuser = '0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] speed_rpm
    logic [1:0]  m_axis_tuser;        // [0] fresh, [1] zero_sum

    // Shadow copy of the block's state
    logic [31:0] period_ring [RING_LEN];
    int unsigned write_slot;
    logic [31:0] prev_stamp;
    logic        mark_seen;

    t_rpm_reading pending_readings[$];
    t_stim_row    stim_rows[$];
    int unsigned  fault_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  rx_hold_cycles = 0;
    bit           no_idle = 1'b0;

    rolling_average_tachometer #(
        .RING_LEN(RING_LEN)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Kill a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Store the wrapping period since the last mark and advance the slot
    function automatic void store_mark_period(input logic [31:0] stamp);
        period_ring[write_slot] = stamp - prev_stamp;
        write_slot = (write_slot + 1) % RING_LEN;
        prev_stamp = stamp;
        mark_seen = 1'b1;
    endfunction

    // Work out the speed from every period except the one at the write slot,
    // hand back the fresh flag and clear it
    function automatic t_rpm_reading predict_speed_reading();
        t_rpm_reading   r;
        logic [63:0]    period_sum;
        logic [63:0]    numerator;
        logic [63:0]    quotient;
        period_sum = '0;
        for (int unsigned i = 0; i < RING_LEN; i++) begin
            if (i != write_slot)
                period_sum += {32'd0, period_ring[i]};
        end
        r.fresh = mark_seen;
        if (period_sum == 64'd0) begin
            r.speed_rpm = 32'hFFFF_FFFF;
            r.zero_sum  = 1'b1;
        end else begin
            numerator = rat_pkg::MICROS_PER_MINUTE * 64'(RING_LEN - 1);
            quotient  = numerator / period_sum;
            r.speed_rpm = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
            r.zero_sum  = 1'b0;
        end
        mark_seen = 1'b0;
        return r;
    endfunction

    task automatic add_row(input logic kind, input logic [31:0] stamp, input logic typed,
                           input logic [31:0] speed, input logic fresh, input logic zero_sum);
        t_stim_row row;
        row.kind    = kind;
        row.stamp   = stamp;
        row.typed   = typed;
        row.reading = '{speed_rpm: speed, fresh: fresh, zero_sum: zero_sum};
        stim_rows.push_back(row);
    endtask

    // Offer one request after a random gap, hold it until accepted, then
    // advance the shadow state and queue the response a read will produce
    task automatic issue_request(input logic kind, input logic [31:0] stamp,
                                 input logic typed, input t_rpm_reading typed_reading);
        int unsigned  gap;
        t_rpm_reading predicted;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= stamp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (kind == rat_pkg::REQ_MARK) begin
            store_mark_period(stamp);
        end else begin
            predicted = predict_speed_reading();
            pending_readings.push_back(typed ? typed_reading : predicted);
        end
    endtask

    // Response side: random ready gaps, an optional long hold-off, and a
    // field-by-field compare against the oldest queued reading
    initial begin : response_side
        int unsigned  gap;
        t_rpm_reading want;
        t_rpm_reading got;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (rx_hold_cycles > 0) begin
                gap += rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.speed_rpm = m_axis_tdata;
            got.fresh     = m_axis_tuser[0];
            got.zero_sum  = m_axis_tuser[1];
            if (pending_readings.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected response: rpm=%0d fresh=%b zero_sum=%b",
                             got.speed_rpm, got.fresh, got.zero_sum);
            end else begin
                want = pending_readings.pop_front();
                if (got.speed_rpm !== want.speed_rpm || got.fresh !== want.fresh ||
                    got.zero_sum !== want.zero_sum) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"mismatch: rpm exp=%0d got=%0d fresh exp=%b got=%b",
                                  " zero_sum exp=%b got=%b"},
                                 want.speed_rpm, got.speed_rpm, want.fresh, got.fresh,
                                 want.zero_sum, got.zero_sum);
                end
            end
        end
    end

    initial begin : request_side
        int unsigned  pick;
        int unsigned  drain;
        logic [31:0]  stamp;
        t_rpm_reading none;
        t_stim_row    row;
        none = '0;
        for (int unsigned i = 0; i < RING_LEN; i++)
            period_ring[i] = '0;
        write_slot = 0;
        prev_stamp = '0;
        mark_seen  = 1'b0;

        // Read right after reset: empty ring saturates, nothing fresh
        add_row(rat_pkg::REQ_READ, 32'hA5A5_A5A5, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // First mark stores timestamp minus zero; a zero period keeps the sum zero
        add_row(rat_pkg::REQ_MARK, 32'h0000_0000, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'h5A5A_5A5A, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Fresh flag was cleared by the previous read
        add_row(rat_pkg::REQ_READ, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Smallest nonzero sum gives the largest speed
        add_row(rat_pkg::REQ_MARK, 32'h0000_0001, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'h0000_0000, 1'b1, 32'd420000000, 1'b1, 1'b0);
        // Timestamp wraps past zero
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'h0000_0003, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'h1234_5678, 1'b0, '0, 1'b0, 1'b0);
        // Repeated timestamp stores a zero period
        add_row(rat_pkg::REQ_MARK, 32'h0000_0003, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'h8765_4321, 1'b0, '0, 1'b0, 1'b0);
        // Fill every slot with the largest period: speed truncates to zero
        add_row(rat_pkg::REQ_MARK, 32'h0000_0002, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'h0000_0001, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'h0000_0000, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFE, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFD, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFC, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_MARK, 32'hFFFF_FFFB, 1'b0, '0, 1'b0, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'hFFFF_0000, 1'b1, 32'd0, 1'b1, 1'b0);
        add_row(rat_pkg::REQ_READ, 32'h0000_FFFF, 1'b1, 32'd0, 1'b0, 1'b0);

        // Hold reset, then release it once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            issue_request(row.kind, row.stamp, row.typed, row.reading);
        end

        // Random part: mostly plausible mark trains with reads in between, plus tiny
        // steps, raw timestamps and stamps near the wrap point as noise
        for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
            // Run stretches with no idling on either side
            no_idle = (n % 300) < 60;

            // Stall the response side and keep pushing reads so the block
            // backs up and drops tready on the request side
            if (n == 500) begin
                rx_hold_cycles = RX_HOLD;
                for (int unsigned k = 0; k < 12; k++)
                    issue_request(rat_pkg::REQ_READ, $urandom, 1'b0, none);
                n += 12;
            end

            // Pause the request side until every pending reading is back;
            // drop tvalid so the last request is not taken again
            if (n == 900 && pending_readings.size() != 0) begin
                s_axis_tvalid <= 1'b0;
                while (pending_readings.size() != 0) @(posedge i_clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                issue_request(rat_pkg::REQ_READ, $urandom, 1'b0, none);
            end else begin
                if (pick < 80)
                    stamp = prev_stamp + $urandom_range(1000, 200000);
                else if (pick < 85)
                    stamp = prev_stamp + $urandom_range(0, 3);
                else if (pick < 95)
                    stamp = $urandom;
                else
                    stamp = 32'hFFFF_FFFF - $urandom_range(0, 50000);
                issue_request(rat_pkg::REQ_MARK, stamp, 1'b0, none);
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        // Drain pending readings, then give the block time to show strays
        drain = 0;
        while (pending_readings.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            fault_count += pending_readings.size();
            $display("%0d readings never returned", pending_readings.size());
        end

        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rat_pkg.sv
rtl/rat_dp.sv
rtl/rat_ctrl.sv
rtl/rolling_average_tachometer.sv
sim/rolling_average_tachometer_tb.sv
